FILE: src/rde_pkg.sv
// shared types and codes for the reversible deque engine
package rde_pkg;

  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_PUSH    = 3'd1;
  localparam logic [2:0] CMD_REVERSE = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_DRAIN   = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_DEL_EMPTY   = 3'd1;
  localparam logic [2:0] ST_DRAIN_EMPTY = 3'd2;
  localparam logic [2:0] ST_REFUSED     = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] value_out;
    logic        last;
    logic [10:0] count;
    logic        error_flag;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_PUSH,
    OP_REVERSE,
    OP_DELETE,
    OP_DRAIN
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] value;
  } op_item_t;

endpackage

FILE: src/reversible_deque_engine.sv
// top level of the reversible deque engine
// Commands enter a two-entry queue and reach the execution side from its
// registered entries; each result passes the result register to the ports.
// Clear, push, reverse and delete are executed as they are taken; a drain
// of a non-empty deque waits in a read state for the registered read of
// the element ram before its result is registered. With the result side
// popping every cycle the block sustains one command per cycle, while a
// drain holds off the next command until its read data is registered. The
// element ram is not cleared after reset; only written entries are ever
// read back.
module reversible_deque_engine #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  rde_pkg::req_t request,
  output logic          empty,
  input  logic          pop,
  output rde_pkg::rsp_t result
);

  import rde_pkg::*;

  logic     item_valid;
  logic     item_take;
  op_item_t item;

  rde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .request    (request),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  rde_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

FILE: src/rde_ram.sv
// generic single write port ram with registered read
module rde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/rde_front.sv
// command intake, decode and two-entry queue toward the execution side
module rde_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  rde_pkg::req_t   request,
  output logic            item_valid,
  output rde_pkg::op_item_t item,
  input  logic            item_take
);

  import rde_pkg::*;

  op_item_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push_fire;
  op_t        op_dec;

  always_comb begin
    unique case (request.command)
      CMD_CLEAR:   op_dec = OP_CLEAR;
      CMD_PUSH:    op_dec = OP_PUSH;
      CMD_REVERSE: op_dec = OP_REVERSE;
      CMD_DELETE:  op_dec = OP_DELETE;
      CMD_DRAIN:   op_dec = OP_DRAIN;
      default:     op_dec = OP_NOP;
    endcase
  end

  assign full       = (fill == 2'd2);
  assign push_fire  = push && !full;
  assign item_valid = (fill != 2'd0);
  assign item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= '{op: op_dec, value: request.value};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push_fire) - 2'(item_take);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");

endmodule

FILE: src/rde_back.sv
// execution side: deque state, element ram and result register
module rde_back #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  rde_pkg::op_item_t item,
  output logic              item_take,
  output logic              empty,
  input  logic              pop,
  output rde_pkg::rsp_t     result
);

  import rde_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic {S_RUN, S_READ} state_t;

  state_t          state;
  logic [AW-1:0]   head;
  logic [CW-1:0]   count;
  logic            reversed;
  logic            error;
  logic            out_valid;
  rsp_t            out_data;
  rsp_t            pend;
  rsp_t            pend_done;

  logic [AW-1:0]   head_next;
  logic [CW-1:0]   count_next;
  logic            reversed_next;
  logic            error_next;
  rsp_t            res_next;
  logic            go_read;

  logic            out_pop;
  logic            is_empty;
  logic            is_full;
  logic [SW-1:0]   back_sum;
  logic [SW-1:0]   front_sum;
  logic [AW-1:0]   back_idx;
  logic [AW-1:0]   front_idx;
  logic [AW-1:0]   head_inc;
  logic [AW-1:0]   head_dec;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [DATA_WIDTH+15:0]  wr_wide;
  logic                    rd_en;
  logic [DATA_WIDTH-1:0]   rd_data;
  logic [DATA_WIDTH+15:0]  rd_wide;
  logic [CW+10:0]          count_wide;

  assign out_pop   = pop && out_valid;
  assign empty     = !out_valid;
  assign result    = out_data;
  assign item_take = item_valid && (state == S_RUN) && (!out_valid || out_pop);

  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(DEPTH));
  assign back_sum  = SW'(head) + SW'(count);
  assign front_sum = SW'(head) + SW'(count) - SW'(1);
  assign back_idx  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign front_idx = !reversed ? head :
                     (front_sum >= SW'(DEPTH)) ? AW'(front_sum - SW'(DEPTH)) : AW'(front_sum);
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  assign wr_wide   = {{DATA_WIDTH{1'b0}}, item.value};
  assign rd_wide   = {16'b0, rd_data};

  always_comb begin
    pend_done           = pend;
    pend_done.value_out = rd_wide[15:0];
  end

  always_comb begin
    head_next     = head;
    count_next    = count;
    reversed_next = reversed;
    error_next    = error;
    wr_en         = 1'b0;
    wr_addr       = back_idx;
    rd_en         = 1'b0;
    go_read       = 1'b0;
    res_next      = '0;
    res_next.status = ST_OK;
    if (item_take) begin
      if (item.op == OP_CLEAR) begin
        head_next     = '0;
        count_next    = '0;
        reversed_next = 1'b0;
        error_next    = 1'b0;
      end else if (error) begin
        res_next.status = ST_REFUSED;
      end else begin
        unique case (item.op)
          OP_PUSH: begin
            if (is_full) begin
              res_next.status = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
              if (reversed) begin
                head_next = head_dec;
                wr_addr   = head_dec;
              end
            end
          end
          OP_REVERSE: begin
            reversed_next = !reversed;
          end
          OP_DELETE: begin
            if (is_empty) begin
              res_next.status = ST_DEL_EMPTY;
              error_next      = 1'b1;
            end else begin
              count_next = count - CW'(1);
              if (!reversed) begin
                head_next = head_inc;
              end
            end
          end
          OP_DRAIN: begin
            if (is_empty) begin
              res_next.status = ST_DRAIN_EMPTY;
            end else begin
              rd_en         = 1'b1;
              go_read       = 1'b1;
              count_next    = count - CW'(1);
              res_next.last = (count == CW'(1));
              if (!reversed) begin
                head_next = head_inc;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    count_wide          = {11'b0, count_next};
    res_next.count      = count_wide[10:0];
    res_next.error_flag = error_next;
  end

  rde_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_wide[DATA_WIDTH-1:0]),
    .rd_en   (rd_en),
    .rd_addr (front_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      head      <= '0;
      count     <= '0;
      reversed  <= 1'b0;
      error     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      head     <= head_next;
      count    <= count_next;
      reversed <= reversed_next;
      error    <= error_next;
      unique case (state)
        S_RUN: begin
          if (go_read) begin
            state <= S_READ;
            pend  <= res_next;
            if (out_pop) begin
              out_valid <= 1'b0;
            end
          end else if (item_take) begin
            out_valid <= 1'b1;
            out_data  <= res_next;
          end else if (out_pop) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          if (!out_valid || out_pop) begin
            state     <= S_RUN;
            out_valid <= 1'b1;
            out_data  <= pend_done;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above depth");

  a_drain_read: assert property (@(posedge clk) disable iff (rst)
    (item_take && item.op == OP_DRAIN && !error && !is_empty) |=> (state == S_READ))
    else $error("drain did not wait for ram data");

  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    (item_take && error && item.op != OP_CLEAR) |=>
      (count == $past(count) && head == $past(head) && reversed == $past(reversed)))
    else $error("refused command changed deque state");

  a_no_write_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !wr_en)
    else $error("ram write while drain data pending");

endmodule
